@@ hw/rtl/uac_pkg.sv @@
// uac_pkg: shared constants and types for the unique address counter
// depends on nothing; used by uac_ram, uac_seq and unique_address_counter
`timescale 1ns / 1ps
`default_nettype none

package uac_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = 48;
    localparam int OUT_W       = 7;
    localparam int OUT_MAX     = (1 << OUT_W) - 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_REPORT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [ADDR_W-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        logic               rpt_fire;
        logic [COUNT_W-1:0] count;
    } seq_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/unique_address_counter.sv @@
// unique_address_counter: counts distinct device addresses per report window
// depends on uac_pkg, uac_ram and uac_seq
//
// channel | dir | tdata              | tuser
// s_      | in  | [47:0] device_addr | [0] action (0 observe, 1 report)
// m_      | out | [6:0] distinct_count, [7] zero | none
//
// an observe beat is accepted, then the table is read once per stored entry
// through the single ram read port and each word compared with the address; after
// the last compare the sequencer decides, and writes the address when it is appended;
// a match ends the scan early
// a report beat waits while a previous result is held
// reset clears the entry count and the result valid flag; the table is not cleared
// a stalled result stays in the output register and holds back the next report
`timescale 1ns / 1ps
`default_nettype none

module unique_address_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [47:0] device_addr
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [6:0] distinct_count
);

    uac_pkg::ram_req_t                       ram_req;
    logic [uac_pkg::ADDR_W-1:0]              ram_rd_data;
    uac_pkg::seq_stat_t                      stat;
    logic                                    out_free;
    logic                                    m_valid_reg, m_valid_next;
    logic [uac_pkg::OUT_W-1:0]               m_data_reg, m_data_next;
    logic [uac_pkg::COUNT_W+uac_pkg::OUT_W-1:0] count_ext;
    logic [uac_pkg::OUT_W-1:0]               count_sat;

    assign out_free = !m_valid_reg || m_tready;

    uac_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    uac_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser[0]),
        .in_addr     (s_tdata),
        .out_free    (out_free),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .stat        (stat)
    );

    assign count_ext = {{uac_pkg::OUT_W{1'b0}}, stat.count};
    assign count_sat = (count_ext > (uac_pkg::COUNT_W + uac_pkg::OUT_W)'(uac_pkg::OUT_MAX))
                     ? uac_pkg::OUT_W'(uac_pkg::OUT_MAX)
                     : count_ext[uac_pkg::OUT_W-1:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (stat.rpt_fire && (stat.count != '0)) begin
            m_valid_next = 1'b1;
            m_data_next  = count_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    a_no_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] != 7'd0))
        else $error("result beat with zero count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= uac_pkg::COUNT_W'(uac_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.rpt_fire |=> (stat.count == '0))
        else $error("count not cleared after report");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(stat.rpt_fire))
        else $error("result beat without a report");

endmodule

`default_nettype wire

@@ hw/rtl/uac_ram.sv @@
// uac_ram: address table, one write port and one registered read port
// depends on uac_pkg
`timescale 1ns / 1ps
`default_nettype none

module uac_ram (
    input  wire logic                      aclk,
    input  wire uac_pkg::ram_req_t         req,
    output logic [uac_pkg::ADDR_W-1:0]     rd_data
);

    logic [uac_pkg::ADDR_W-1:0] addr_mem [uac_pkg::TABLE_DEPTH];
    logic [uac_pkg::ADDR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            addr_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= addr_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/uac_seq.sv @@
// uac_seq: sequencer, entry counter and shared address comparator
// depends on uac_pkg; drives the uac_ram port
`timescale 1ns / 1ps
`default_nettype none

module uac_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_action,
    input  wire logic [uac_pkg::ADDR_W-1:0]    in_addr,
    input  wire logic                          out_free,
    output uac_pkg::ram_req_t                  ram_req,
    input  wire logic [uac_pkg::ADDR_W-1:0]    ram_rd_data,
    output uac_pkg::seq_stat_t                 stat
);

    uac_pkg::state_t                state_reg, state_next;
    logic [uac_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [uac_pkg::COUNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic [uac_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic                           rd_en;
    logic                           hit;
    logic                           room;
    logic                           rpt_fire;

    assign rd_en = (state_reg == uac_pkg::ST_SCAN) && (rd_idx_reg < count_reg);
    assign hit   = cmp_vld_reg && (ram_rd_data == addr_reg);
    assign room  = count_reg < uac_pkg::COUNT_W'(uac_pkg::TABLE_DEPTH);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = 1'b0;
        addr_next    = addr_reg;
        in_ready     = 1'b0;
        rpt_fire     = 1'b0;
        case (state_reg)
            uac_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_action == uac_pkg::ACT_REPORT) begin
                        state_next = uac_pkg::ST_REPORT;
                    end else begin
                        addr_next   = in_addr;
                        rd_idx_next = '0;
                        state_next  = uac_pkg::ST_SCAN;
                    end
                end
            end
            uac_pkg::ST_SCAN: begin
                cmp_vld_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (hit) begin
                    cmp_vld_next = 1'b0;
                    state_next   = uac_pkg::ST_IDLE;
                end else if (!rd_en && !cmp_vld_reg) begin
                    state_next = room ? uac_pkg::ST_WRITE : uac_pkg::ST_IDLE;
                end
            end
            uac_pkg::ST_WRITE: begin
                count_next = count_reg + 1'b1;
                state_next = uac_pkg::ST_IDLE;
            end
            uac_pkg::ST_REPORT: begin
                if (out_free) begin
                    rpt_fire   = 1'b1;
                    count_next = '0;
                    state_next = uac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = uac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= uac_pkg::ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        addr_reg   <= addr_next;
    end

    assign ram_req.rd_en   = rd_en;
    assign ram_req.rd_addr = rd_idx_reg[uac_pkg::IDX_W-1:0];
    assign ram_req.wr_en   = (state_reg == uac_pkg::ST_WRITE);
    assign ram_req.wr_addr = count_reg[uac_pkg::IDX_W-1:0];
    assign ram_req.wr_data = addr_reg;
    assign stat.rpt_fire   = rpt_fire;
    assign stat.count      = count_reg;

endmodule

`default_nettype wire
